### rtl/core/tridiagonal_thomas_solver_core_defines.svh
// Assertion macros for the tridiagonal solver core.
// No dependencies.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_CORE_DEFINES_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_CORE_DEFINES_SVH
// a implies b on the same edge
`define TTS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: check failed");
// a implies b on the following edge
`define TTS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: check failed");
`endif

### rtl/core/tts_pkg.sv
// Package for the tridiagonal solver core: sizes, status codes, states, helpers.
// No dependencies.
package tts_pkg;
    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = ROW_W + 1;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NODOM  = 2'd1;
    localparam t_status ST_ZPIVOT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_PREP, S_DIV_U, S_DIV_Q, S_WRITE,
        S_ERR, S_BS_RD, S_BS_MUL, S_BS_OUT, S_DONE
    } t_state;

    typedef struct packed {
        logic            start;
        logic            neg;
        logic [DIV_W-1:0] num;
        logic [31:0]     den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor product shifted down; arithmetic shift gives floor
    function automatic logic signed [63:0] fxshift(input logic signed [63:0] p);
        return p >>> FRAC_BITS;
    endfunction
endpackage

### rtl/core/tts_if.sv
// Valid/ready channel interfaces for row and result words.
// Depends on nothing.
interface tts_row_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sub_diag;
    logic signed [31:0] diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
    modport source (output valid, sub_diag, diag, super_diag, rhs, last_row, input ready);
    modport sink   (input valid, sub_diag, diag, super_diag, rhs, last_row, output ready);
endinterface

interface tts_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic [1:0]         status;
    logic               last_result;
    modport source (output valid, solution, row_index, status, last_result, input ready);
    modport sink   (input valid, solution, row_index, status, last_result, output ready);
endinterface

### rtl/core/tts_div.sv
// Restoring divider, one quotient bit per cycle, truncating, saturating to 32 bits.
// Depends on tts_pkg.
module tts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tts_pkg::t_div_req i_req,
    output tts_pkg::t_div_rsp o_rsp
);
    import tts_pkg::*;

    logic              r_busy, n_busy;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [32:0]       r_rem, n_rem;
    logic [31:0]       r_den, n_den;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [33:0]       w_sh;
    logic [DIV_W-1:0]  w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        w_sh   = {r_rem, r_quo[DIV_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIV_W);
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_neg  = i_req.neg;
        end else if (r_busy) begin
            if (w_sh >= {2'b00, r_den}) begin
                n_rem = 33'(w_sh - {2'b00, r_den});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[32:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // magnitude quotient to signed saturated result
    always_comb begin
        w_fin = r_quo;
        o_rsp.done = r_done;
        if (r_neg) begin
            if (w_fin > DIV_W'(33'h080000000)) o_rsp.quot = 32'h80000000;
            else o_rsp.quot = 32'(-w_fin);
        end else begin
            if (w_fin > DIV_W'(32'h7fffffff)) o_rsp.quot = 32'h7fffffff;
            else o_rsp.quot = w_fin[31:0];
        end
    end
endmodule

### rtl/core/tts_store.sv
// Coefficient memory holding u and q per row, with a registered read.
// Depends on tts_pkg.
module tts_store (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [tts_pkg::ROW_W-1:0] i_waddr,
    input  logic [63:0]              i_wdata,
    input  logic [tts_pkg::ROW_W-1:0] i_raddr,
    output logic [63:0]              o_rdata
);
    import tts_pkg::*;

    logic [63:0] r_mem [MAX_ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/tridiagonal_thomas_solver_core.sv
// Thomas tridiagonal solver, signed Q16.16, one row word per input.
// Forward sweep per row: multiply, prepare, then two serial divides (u, then q) and a write.
// Last row then back substitution: memory read, multiply, output per solution word.
// Error run: a single result word after the last row, through S_WRITE and S_ERR; a last row
// with a zero pivot first passes S_MUL, S_PREP and S_DIV_U. One row in flight at a time.
// Reset (synchronous, active low) clears the sweep state; the u/q memory is not cleared.
`include "tridiagonal_thomas_solver_core_defines.svh"
module tridiagonal_thomas_solver_core (
    input  logic i_clk,
    input  logic i_rst_n,
    tts_row_if.sink   i_row,
    tts_res_if.source o_res
);
    import tts_pkg::*;

    t_state r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [31:0] r_pu, n_pu, r_pq, n_pq;
    t_status r_err, n_err;
    logic [ROW_W-1:0] r_erow, n_erow;
    // latched row
    logic signed [31:0] r_a, r_b, r_c, r_d, r_den, r_num;
    logic signed [63:0] r_p1, r_p2;
    logic [ROW_W-1:0] r_idx;
    logic r_last;
    logic signed [31:0] r_u;
    logic signed [31:0] r_x, n_x;
    logic [ROW_W-1:0] r_k, n_k;
    logic signed [63:0] r_bp;
    logic r_ov, n_ov;
    logic signed [31:0] r_os, n_os;
    logic [ROW_W-1:0] r_orow, n_orow;
    t_status r_ost, n_ost;
    logic r_olast, n_olast;

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic w_we;
    logic [ROW_W-1:0] w_raddr;
    logic [63:0] w_rd;
    logic w_acc;
    logic w_last_in;
    logic signed [31:0] w_a, w_c;
    logic [33:0] w_aa, w_ab, w_ac;
    logic w_nodom;
    logic signed [31:0] w_den, w_num;

    tts_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));
    tts_store u_store (.i_clk, .i_we(w_we), .i_waddr(r_idx),
        .i_wdata({r_u, w_drsp.quot}), .i_raddr(w_raddr), .o_rdata(w_rd));

    assign i_row.ready = (r_st == S_IDLE) && !r_ov;
    assign w_acc = i_row.valid && i_row.ready;
    assign w_last_in = i_row.last_row || (r_cnt >= CNT_W'(MAX_ROWS - 1));
    assign w_a = (r_cnt == '0) ? 32'sd0 : i_row.sub_diag;
    assign w_c = w_last_in ? 32'sd0 : i_row.super_diag;
    assign w_aa = w_a[31] ? 34'(-{{2{w_a[31]}}, w_a}) : 34'({2'b00, w_a});
    assign w_ac = w_c[31] ? 34'(-{{2{w_c[31]}}, w_c}) : 34'({2'b00, w_c});
    assign w_ab = i_row.diag[31] ? 34'(-{{2{i_row.diag[31]}}, i_row.diag})
                                 : 34'({2'b00, i_row.diag});
    assign w_nodom = w_ab < 34'(w_aa + w_ac);
    assign w_den = sat32(66'(r_b) - 66'(fxshift(r_p1)));
    assign w_num = sat32(66'(r_d) - 66'(fxshift(r_p2)));
    assign w_we = (r_st == S_DIV_Q) && w_drsp.done;
    assign w_raddr = (r_st == S_IDLE) ? r_idx : r_k;

    assign o_res.valid = r_ov;
    assign o_res.solution = r_os;
    assign o_res.row_index = 6'(r_orow);
    assign o_res.status = r_ost;
    assign o_res.last_result = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_pu  <= '0;
            r_pq  <= '0;
            r_err <= ST_OK;
            r_erow <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_pu  <= n_pu;
            r_pq  <= n_pq;
            r_err <= n_err;
            r_erow <= n_erow;
            r_ov  <= n_ov;
        end
        if (w_acc) begin
            r_a <= w_a; r_b <= i_row.diag; r_c <= w_c; r_d <= i_row.rhs;
            r_idx <= r_cnt[ROW_W-1:0]; r_last <= w_last_in;
        end
        if (r_st == S_MUL) begin
            r_p1 <= 64'(r_pu) * 64'(r_a);
            r_p2 <= 64'(r_pq) * 64'(r_a);
        end
        if (r_st == S_PREP) begin
            r_den <= w_den;
            r_num <= w_num;
        end
        if (r_st == S_DIV_U && w_drsp.done) r_u <= w_drsp.quot;
        // read data of row k is valid in S_BS_MUL, the state after S_BS_RD
        if (r_st == S_BS_MUL) r_bp <= 64'($signed(w_rd[63:32])) * 64'(r_x);
        r_x <= n_x; r_k <= n_k;
        r_os <= n_os; r_orow <= n_orow; r_ost <= n_ost; r_olast <= n_olast;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_pu = r_pu; n_pq = r_pq;
        n_err = r_err; n_erow = r_erow; n_x = r_x; n_k = r_k;
        n_ov = r_ov && !o_res.ready;
        n_os = r_os; n_orow = r_orow; n_ost = r_ost; n_olast = r_olast;
        w_dreq = '0;
        unique case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_nodom) begin
                        if (r_err != ST_NODOM) begin
                            n_err = ST_NODOM; n_erow = r_cnt[ROW_W-1:0];
                        end
                        n_st = S_WRITE;
                    end else if (r_err == ST_OK) begin
                        n_st = S_MUL;
                    end else begin
                        n_st = S_WRITE;
                    end
                end
            end
            S_MUL: n_st = S_PREP;
            S_PREP: n_st = S_DIV_U;
            S_DIV_U: begin
                if (w_drsp.done) n_st = S_DIV_Q;
                else if (r_den == 0) begin
                    n_err = ST_ZPIVOT; n_erow = r_idx; n_st = S_WRITE;
                end
            end
            S_DIV_Q: if (w_drsp.done) begin
                n_pu = r_u; n_pq = w_drsp.quot; n_st = S_WRITE;
            end
            S_WRITE: begin
                if (!r_last) begin
                    n_cnt = r_cnt + 1'b1; n_st = S_IDLE;
                end else if (r_err != ST_OK) n_st = S_ERR;
                else begin
                    n_k = r_idx; n_x = '0; n_st = S_BS_RD;
                end
            end
            S_ERR: if (!r_ov) begin
                n_ov = 1'b1; n_os = '0; n_orow = r_erow; n_ost = r_err; n_olast = 1'b1;
                n_st = S_DONE;
            end
            S_BS_RD: n_st = S_BS_MUL;
            S_BS_MUL: n_st = S_BS_OUT;
            S_BS_OUT: if (!r_ov) begin
                if (r_k == r_idx) n_x = $signed(w_rd[31:0]);
                else n_x = sat32(66'($signed(w_rd[31:0])) - 66'(fxshift(r_bp)));
                n_ov = 1'b1; n_os = n_x; n_orow = r_k; n_ost = ST_OK;
                n_olast = (r_k == '0);
                if (r_k == '0) n_st = S_DONE;
                else begin
                    n_k = r_k - 1'b1; n_st = S_BS_RD;
                end
            end
            S_DONE: begin
                n_cnt = '0; n_pu = '0; n_pq = '0; n_err = ST_OK; n_erow = '0;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        // divider launches
        if (r_st == S_PREP && w_den != 0) begin
            w_dreq.start = 1'b1;
            w_dreq.neg = r_c[31] ^ w_den[31];
            w_dreq.num = DIV_W'({(r_c[31] ? 32'(-r_c) : 32'(r_c)), {FRAC_BITS{1'b0}}});
            w_dreq.den = w_den[31] ? 32'(-w_den) : 32'(w_den);
        end
        if (r_st == S_DIV_U && w_drsp.done) begin
            w_dreq.start = 1'b1;
            w_dreq.neg = r_num[31] ^ r_den[31];
            w_dreq.num = DIV_W'({(r_num[31] ? 32'(-r_num) : 32'(r_num)),
                                 {FRAC_BITS{1'b0}}});
            w_dreq.den = r_den[31] ? 32'(-r_den) : 32'(r_den);
        end
    end

    `TTS_ASSERT_IMP(a_in_idle, i_clk, i_rst_n, w_acc, r_st == S_IDLE)
    `TTS_ASSERT_IMP(a_we_nodone, i_clk, i_rst_n, w_we, r_err == ST_OK)
    `TTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !o_res.ready, r_ov)
endmodule

### tb/sv/tb.sv
// Self-checking bench for the Thomas tridiagonal solver core.
// Depends on tts_pkg, tts_if.sv and the tridiagonal_thomas_solver_core RTL.
module tb;
    import tts_pkg::*;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs;
        logic               last_row;
    } t_row;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [5:0]         row_index;
        t_status            status;
        logic               last_result;
    } t_sol;

    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    tts_row_if row_ch();
    tts_res_if res_ch();

    tridiagonal_thomas_solver_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_ch.sink),
        .o_res  (res_ch.source)
    );

    // sweep state of the predictor
    logic signed [63:0] u_mem [MAX_ROWS];
    logic signed [63:0] q_mem [MAX_ROWS];
    int                 rows_seen;
    logic signed [63:0] u_prev, q_prev;
    t_status            err_code;
    int                 err_at;

    t_row  pending_rows[$];
    t_sol  expected_sols[$];
    int    mismatches, sols_seen, runs_done;
    longint cycles;
    bit    stim_done;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor product: arithmetic shift of a signed 64-bit value floors
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic signed [63:0] scaled;
        scaled = num <<< FRAC_BITS;
        return clamp32(scaled / den);
    endfunction

    function automatic logic signed [63:0] mag(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic clear_sweep();
        rows_seen = 0;
        u_prev = 0;
        q_prev = 0;
        err_code = ST_OK;
        err_at = 0;
    endtask

    // forward sweep on one row; on the closing row queue the solution words, or a single error word
    task automatic sweep_row(input t_row r);
        int                 idx, k;
        bit                 fin;
        logic signed [63:0] a, b, c, d, den, num, x;
        t_sol               s;
        idx = rows_seen;
        fin = r.last_row || (idx >= MAX_ROWS - 1);
        a = (idx == 0) ? 64'sd0 : 64'(r.sub_diag);
        b = 64'(r.diag);
        c = fin ? 64'sd0 : 64'(r.super_diag);
        d = 64'(r.rhs);
        if (mag(b) < mag(a) + mag(c)) begin
            if (err_code != ST_NODOM) begin
                err_code = ST_NODOM;
                err_at = idx;
            end
        end else if (err_code == ST_OK) begin
            den = clamp32(b - fx_mul(u_prev, a));
            if (den == 0) begin
                err_code = ST_ZPIVOT;
                err_at = idx;
            end else begin
                num = clamp32(d - fx_mul(q_prev, a));
                u_prev = fx_div(c, den);
                q_prev = fx_div(num, den);
                u_mem[idx] = u_prev;
                q_mem[idx] = q_prev;
            end
        end
        if (!fin) begin
            rows_seen = idx + 1;
            return;
        end
        if (err_code != ST_OK) begin
            s.solution = '0;
            s.row_index = 6'(err_at);
            s.status = err_code;
            s.last_result = 1'b1;
            expected_sols.push_back(s);
        end else begin
            x = 0;
            for (k = idx; k >= 0; k--) begin
                if (k == idx) x = q_mem[k];
                else x = clamp32(q_mem[k] - fx_mul(u_mem[k], x));
                s.solution = x[31:0];
                s.row_index = 6'(k);
                s.status = ST_OK;
                s.last_result = (k == 0);
                expected_sols.push_back(s);
            end
        end
        clear_sweep();
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // dominant row with random content, small values keep the sweep meaningful
    function automatic t_row dominant_row(input bit fin);
        t_row r;
        int   sa, sc;
        sa = $urandom_range(0, 32'h20000);
        sc = $urandom_range(0, 32'h20000);
        r.sub_diag = $urandom_range(0, 1) ? sa : -sa;
        r.super_diag = $urandom_range(0, 1) ? sc : -sc;
        r.diag = sa + sc + $urandom_range(0, 32'h40000);
        if ($urandom_range(0, 1)) r.diag = -r.diag;
        r.rhs = ($urandom_range(0, 7) == 0) ? rand_word() : $signed($urandom) >>> 8;
        r.last_row = fin;
        return r;
    endfunction

    task automatic add_system(input int n, input int mode);
        t_row r;
        int   i;
        for (i = 0; i < n; i++) begin
            r = dominant_row(i == n - 1);
            if (mode == 1 && i == n / 2) r.diag = 0;  // breaks dominance
            if (mode == 2) begin                        // raw noise
                r.sub_diag = rand_word();
                r.diag = rand_word();
                r.super_diag = rand_word();
                r.rhs = rand_word();
            end
            pending_rows.push_back(r);
        end
    endtask

    // ---------------- driver ----------------
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_ch.valid <= 1'b0;
            drv_gap <= $urandom_range(0, 10);
        end else if (row_ch.valid && !row_ch.ready) begin
            // hold the word until accepted
        end else begin
            if (row_ch.valid) begin
                sweep_row(t_row'({row_ch.sub_diag, row_ch.diag, row_ch.super_diag,
                                  row_ch.rhs, row_ch.last_row}));
            end
            if (drv_gap > 0 || pending_rows.size() == 0) begin
                row_ch.valid <= 1'b0;
                if (drv_gap > 0) drv_gap <= drv_gap - 1;
            end else begin
                t_row r;
                r = pending_rows.pop_front();
                row_ch.valid <= 1'b1;
                row_ch.sub_diag <= r.sub_diag;
                row_ch.diag <= r.diag;
                row_ch.super_diag <= r.super_diag;
                row_ch.rhs <= r.rhs;
                row_ch.last_row <= r.last_row;
                drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // ---------------- monitor ----------------
    int mon_gap;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_sol got, want;
                got = {res_ch.solution, res_ch.row_index, res_ch.status, res_ch.last_result};
                sols_seen++;
                if (got.last_result) runs_done++;
                if (expected_sols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected solution word %h row %0d", got.solution,
                                 got.row_index);
                end else begin
                    want = expected_sols.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%h row=%0d st=%0d last=%b, got x=%h row=%0d st=%0d last=%b",
                                     want.solution, want.row_index, want.status,
                                     want.last_result, got.solution, got.row_index,
                                     got.status, got.last_result);
                    end
                end
                mon_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
                res_ch.ready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   n, sel;
        cycles = 0;
        mismatches = 0;
        sols_seen = 0;
        runs_done = 0;
        row_ch.valid = 1'b0;
        row_ch.sub_diag = '0;
        row_ch.diag = '0;
        row_ch.super_diag = '0;
        row_ch.rhs = '0;
        row_ch.last_row = 1'b0;
        res_ch.ready = 1'b0;
        clear_sweep();

        // directed: single row, field extremes, zero pivot, dominance error, max length
        r = '{sub_diag: 32'h7fffffff, diag: 32'h00010000, super_diag: 32'h80000000,
              rhs: 32'h7fffffff, last_row: 1'b1};
        pending_rows.push_back(r);
        r = '{sub_diag: 0, diag: 32'h80000000, super_diag: 0, rhs: 32'h80000000,
              last_row: 1'b1};
        pending_rows.push_back(r);
        r = '{sub_diag: 0, diag: 32'h00000001, super_diag: 0, rhs: 32'h7fffffff,
              last_row: 1'b1};
        pending_rows.push_back(r);
        // zero pivot on row 0
        r = '{sub_diag: 32'hffffffff, diag: 0, super_diag: 0, rhs: 5, last_row: 1'b0};
        pending_rows.push_back(r);
        r = '{sub_diag: 0, diag: 32'h00010000, super_diag: 0, rhs: 5, last_row: 1'b1};
        pending_rows.push_back(r);
        // zero pivot later: den = b - u*a = 1 - 1 = 0; then a dominance error wins
        r = '{sub_diag: 0, diag: 32'h00020000, super_diag: 32'h00020000, rhs: 1,
              last_row: 1'b0};
        pending_rows.push_back(r);
        r = '{sub_diag: 32'h00010000, diag: 32'h00010000, super_diag: 0, rhs: 1,
              last_row: 1'b0};
        pending_rows.push_back(r);
        r = '{sub_diag: 32'h7fffffff, diag: 1, super_diag: 32'h7fffffff,
              rhs: 32'h80000000, last_row: 1'b1};
        pending_rows.push_back(r);
        add_system(3, 1);
        add_system(MAX_ROWS, 0);  // last row flagged and at the length limit
        add_system(2, 0);

        #1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random systems: mostly well-formed, some broken or noise
        while (pending_rows.size() < 370) begin
            sel = $urandom_range(0, 9);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            add_system(n, sel < 7 ? 0 : (sel < 9 ? 1 : 2));
        end

        wait (pending_rows.size() == 0 && !row_ch.valid);
        wait (expected_sols.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("solved %0d systems, checked %0d solution words, %0d mismatches",
                 runs_done, sols_seen, mismatches);
        if (mismatches == 0 && expected_sols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_if.sv
rtl/core/tts_div.sv
rtl/core/tts_store.sv
rtl/core/tridiagonal_thomas_solver_core.sv
tb/sv/tb.sv
